[design/dmsd_pkg.sv]
// ----------------------------------------------------------------------------
// Dual meter slew driver package
// Shared widths, command codes, register indexes and the configuration
// bundle passed from the register block to the datapath.
// ----------------------------------------------------------------------------
package dmsd_pkg;

   localparam int CMD_W    = 2;
   localparam int PCT_W    = 8;
   localparam int PCTC_W   = 7;   // a percentage once saturated to 100
   localparam int FS_W     = 12;
   localparam int MS_W     = 8;
   localparam int LIM_W    = 16;
   localparam int SINCE_W  = 17;
   localparam int PROD_W   = PCTC_W + FS_W;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [PCT_W-1:0]   PCT_FULL       = 8'd100;
   localparam logic [FS_W-1:0]    FULL_SCALE_RST = 12'd3722;
   localparam logic [MS_W-1:0]    MIN_STEP_RST   = 8'd10;
   localparam logic [LIM_W-1:0]   STALE_LIM_RST  = 16'd20000;
   localparam logic [SINCE_W-1:0] SINCE_MAX      = {SINCE_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_SET  = 2'd0,
      CMD_MOVE = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_FULL_SCALE = 2'd0,
      REG_MIN_STEP   = 2'd1,
      REG_STALE_LIM  = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [FS_W-1:0]  full_scale;
      logic [MS_W-1:0]  min_step;
      logic [LIM_W-1:0] stale_limit_ms;
   } cfg_type;

endpackage

[design/dmsd_div100.sv]
// ----------------------------------------------------------------------------
// Divide by one hundred
// Unsigned floor division by 100 through a multiply by a rounded-up
// reciprocal and a shift; exact for every W-bit dividend.
// ----------------------------------------------------------------------------
module dmsd_div100 #(
   parameter int W = 12
) (
   input  logic [W-1:0] num,
   output logic [W-1:0] quo
);

   // With a shift of W+8 the reciprocal error stays below the bound that
   // keeps the truncated product equal to the true quotient.
   localparam int SH = W + 8;
   localparam longint unsigned MUL = ((64'd1 << SH) + 64'd99) / 64'd100;
   localparam int MW = $clog2(MUL + 64'd1);
   localparam int PW = W + MW;

   logic [PW-1:0] prod;

   assign prod = PW'(num) * PW'(MUL);
   assign quo  = W'(prod >> SH);

endmodule

[design/dmsd_slew.sv]
// ----------------------------------------------------------------------------
// Slew step for one meter channel
// Moves the level toward its target by one hundredth of the distance,
// never less than the minimum step and never past the target.
// ----------------------------------------------------------------------------
module dmsd_slew #(
   parameter int W = 12
) (
   input  logic [W-1:0]               level,
   input  logic [W-1:0]               target,
   input  logic [dmsd_pkg::MS_W-1:0]  min_step,
   output logic [W-1:0]               level_next
);

   logic         rising;
   logic [W-1:0] mag;
   logic [W-1:0] frac;
   logic [W-1:0] ms_ext;
   logic [W-1:0] step;

   assign rising = target > level;
   assign mag    = rising ? (target - level) : (level - target);
   assign ms_ext = W'(min_step);

   dmsd_div100 #(.W(W)) u_div (
      .num (mag),
      .quo (frac)
   );

   always_comb begin
      if (frac < ms_ext) begin
         step = (mag > ms_ext) ? ms_ext : mag;
      end else begin
         step = frac;
      end
      level_next = rising ? (level + step) : (level - step);
   end

endmodule

[design/dmsd_csr.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register block holding full scale, minimum step and the stale
// limit, with read-back.
// ----------------------------------------------------------------------------
module dmsd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dmsd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dmsd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dmsd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output dmsd_pkg::cfg_type            cfg
);

   dmsd_pkg::cfg_type cfg_ff;
   dmsd_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            dmsd_pkg::REG_FULL_SCALE: begin
               cfg_in.full_scale = csr_pwdata[dmsd_pkg::FS_W-1:0];
            end
            dmsd_pkg::REG_MIN_STEP: begin
               cfg_in.min_step = csr_pwdata[dmsd_pkg::MS_W-1:0];
            end
            dmsd_pkg::REG_STALE_LIM: begin
               cfg_in.stale_limit_ms = csr_pwdata[dmsd_pkg::LIM_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         dmsd_pkg::REG_FULL_SCALE: csr_prdata = dmsd_pkg::DATA_W'(cfg_ff.full_scale);
         dmsd_pkg::REG_MIN_STEP:   csr_prdata = dmsd_pkg::DATA_W'(cfg_ff.min_step);
         dmsd_pkg::REG_STALE_LIM:  csr_prdata = dmsd_pkg::DATA_W'(cfg_ff.stale_limit_ms);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale     <= dmsd_pkg::FULL_SCALE_RST;
         cfg_ff.min_step       <= dmsd_pkg::MIN_STEP_RST;
         cfg_ff.stale_limit_ms <= dmsd_pkg::STALE_LIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/dual_meter_slew_driver_unit.sv]
// ----------------------------------------------------------------------------
// Dual meter slew driver
// Slew-limited DAC level generator for a downstream and an upstream panel
// meter, with a stale indicator fed by a millisecond tick.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_stall is low and returns
// exactly one response for each, in order, through the first-stage and the
// response registers. A set request saturates both percentages to 100 and
// scales them to DAC targets as pct*full_scale/100, and restarts the
// millisecond counter. A move request steps each level toward its target by
// one hundredth of the distance, at least min_step, never overshooting, and
// reports in moved whether either level changed. A tick request advances the
// saturating millisecond counter. Every response shows both levels and the
// stale flag as they stand after the request. The first stage multiplies the
// clamped percentages by full_scale and registers the products; the second
// stage divides by 100, applies the slew step to the channel state and loads
// the response register. Each stage holds one item, so a new request is taken
// in every cycle in which the response register is free or being emptied.
// Configuration registers should be written only while the block is idle.
module dual_meter_slew_driver_unit #(
   parameter int DAC_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dmsd_pkg::CMD_W-1:0]   req_cmd,
   input  logic [dmsd_pkg::PCT_W-1:0]   req_down_pct,
   input  logic [dmsd_pkg::PCT_W-1:0]   req_up_pct,
   // Response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DAC_BITS-1:0]          rsp_down_level,
   output logic [DAC_BITS-1:0]          rsp_up_level,
   output logic                         rsp_stale,
   output logic                         rsp_moved,
   // Configuration port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dmsd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dmsd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dmsd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   // Scaled targets are at most FS_W bits wide; they are clamped to the DAC
   // range when the DAC is narrower than the full-scale register.
   localparam int SW = (DAC_BITS > dmsd_pkg::FS_W) ? DAC_BITS : dmsd_pkg::FS_W;
   localparam logic [SW-1:0] DAC_MAX = SW'((64'd1 << DAC_BITS) - 64'd1);

   dmsd_pkg::cfg_type cfg;

   dmsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Flow control. The second stage drains whenever the response register
   // is empty or its transfer completes in this cycle.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // ------------------------------------------------------------------
   // First stage: saturate the percentages and scale by full_scale.
   // ------------------------------------------------------------------
   logic [dmsd_pkg::PCTC_W-1:0] down_pct_sat;
   logic [dmsd_pkg::PCTC_W-1:0] up_pct_sat;
   logic [dmsd_pkg::CMD_W-1:0]  s1_cmd_ff;
   logic [dmsd_pkg::PROD_W-1:0] s1_down_prod_ff;
   logic [dmsd_pkg::PROD_W-1:0] s1_up_prod_ff;

   assign down_pct_sat = (req_down_pct > dmsd_pkg::PCT_FULL)
                       ? dmsd_pkg::PCTC_W'(dmsd_pkg::PCT_FULL)
                       : req_down_pct[dmsd_pkg::PCTC_W-1:0];
   assign up_pct_sat   = (req_up_pct > dmsd_pkg::PCT_FULL)
                       ? dmsd_pkg::PCTC_W'(dmsd_pkg::PCT_FULL)
                       : req_up_pct[dmsd_pkg::PCTC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff       <= req_cmd;
         s1_down_prod_ff <= dmsd_pkg::PROD_W'(down_pct_sat) *
                            dmsd_pkg::PROD_W'(cfg.full_scale);
         s1_up_prod_ff   <= dmsd_pkg::PROD_W'(up_pct_sat) *
                            dmsd_pkg::PROD_W'(cfg.full_scale);
      end
   end

   // ------------------------------------------------------------------
   // Second stage: divide the products, slew the levels, update state.
   // ------------------------------------------------------------------
   logic [dmsd_pkg::PROD_W-1:0] down_quo;
   logic [dmsd_pkg::PROD_W-1:0] up_quo;
   logic [SW-1:0]               down_scaled;
   logic [SW-1:0]               up_scaled;
   logic [DAC_BITS-1:0]         down_tgt_new;
   logic [DAC_BITS-1:0]         up_tgt_new;

   dmsd_div100 #(.W(dmsd_pkg::PROD_W)) u_down_div (
      .num (s1_down_prod_ff),
      .quo (down_quo)
   );

   dmsd_div100 #(.W(dmsd_pkg::PROD_W)) u_up_div (
      .num (s1_up_prod_ff),
      .quo (up_quo)
   );

   assign down_scaled  = SW'(down_quo[dmsd_pkg::FS_W-1:0]);
   assign up_scaled    = SW'(up_quo[dmsd_pkg::FS_W-1:0]);
   assign down_tgt_new = (down_scaled > DAC_MAX) ? DAC_MAX[DAC_BITS-1:0]
                                                 : down_scaled[DAC_BITS-1:0];
   assign up_tgt_new   = (up_scaled > DAC_MAX) ? DAC_MAX[DAC_BITS-1:0]
                                               : up_scaled[DAC_BITS-1:0];

   logic [DAC_BITS-1:0]          down_target_ff, down_target_in;
   logic [DAC_BITS-1:0]          up_target_ff, up_target_in;
   logic [DAC_BITS-1:0]          down_level_ff, down_level_in;
   logic [DAC_BITS-1:0]          up_level_ff, up_level_in;
   logic [dmsd_pkg::SINCE_W-1:0] since_ff, since_in;
   logic [DAC_BITS-1:0]          down_slewed;
   logic [DAC_BITS-1:0]          up_slewed;
   logic                         moved;

   dmsd_slew #(.W(DAC_BITS)) u_down_slew (
      .level      (down_level_ff),
      .target     (down_target_ff),
      .min_step   (cfg.min_step),
      .level_next (down_slewed)
   );

   dmsd_slew #(.W(DAC_BITS)) u_up_slew (
      .level      (up_level_ff),
      .target     (up_target_ff),
      .min_step   (cfg.min_step),
      .level_next (up_slewed)
   );

   always_comb begin
      down_target_in = down_target_ff;
      up_target_in   = up_target_ff;
      down_level_in  = down_level_ff;
      up_level_in    = up_level_ff;
      since_in       = since_ff;
      moved          = 1'b0;
      case (s1_cmd_ff)
         dmsd_pkg::CMD_SET: begin
            down_target_in = down_tgt_new;
            up_target_in   = up_tgt_new;
            since_in       = '0;
         end
         dmsd_pkg::CMD_MOVE: begin
            down_level_in = down_slewed;
            up_level_in   = up_slewed;
            moved         = (down_slewed != down_level_ff) | (up_slewed != up_level_ff);
         end
         dmsd_pkg::CMD_TICK: begin
            if (since_ff != dmsd_pkg::SINCE_MAX) begin
               since_in = since_ff + 1'b1;
            end
         end
         default: begin
            moved = 1'b0;
         end
      endcase
   end

   // The channel state changes only when an item leaves the second stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         down_target_ff <= '0;
         up_target_ff   <= '0;
         down_level_ff  <= '0;
         up_level_ff    <= '0;
         since_ff       <= '0;
      end else if (s1_valid_ff & advance) begin
         down_target_ff <= down_target_in;
         up_target_ff   <= up_target_in;
         down_level_ff  <= down_level_in;
         up_level_ff    <= up_level_in;
         since_ff       <= since_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   logic [DAC_BITS-1:0] rsp_down_ff;
   logic [DAC_BITS-1:0] rsp_up_ff;
   logic                rsp_stale_ff;
   logic                rsp_moved_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff & advance) begin
         rsp_down_ff  <= down_level_in;
         rsp_up_ff    <= up_level_in;
         rsp_stale_ff <= since_in > dmsd_pkg::SINCE_W'(cfg.stale_limit_ms);
         rsp_moved_ff <= moved;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_down_level = rsp_down_ff;
   assign rsp_up_level   = rsp_up_ff;
   assign rsp_stale      = rsp_stale_ff;
   assign rsp_moved      = rsp_moved_ff;

endmodule

[verif/dual_meter_slew_driver_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual meter slew driver testbench
// Drives set, move, tick and unused requests into the slew driver under
// several register settings and random stalls on both channels. Every
// response is compared field by field with a cycle-free prediction of the
// meter levels, the stale flag and the moved flag.
// ----------------------------------------------------------------------------
module dual_meter_slew_driver_unit_tb;

   // Code 3 is not a command; the block must answer it without changing state.
   localparam logic [dmsd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // One response as the meters should show it.
   typedef struct {
      logic [dmsd_pkg::FS_W-1:0] down_level;
      logic [dmsd_pkg::FS_W-1:0] up_level;
      logic                      stale;
      logic                      moved;
   } meter_reading_type;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [dmsd_pkg::CMD_W-1:0]    req_cmd      = dmsd_pkg::CMD_SET;
   logic [dmsd_pkg::PCT_W-1:0]    req_down_pct = '0;
   logic [dmsd_pkg::PCT_W-1:0]    req_up_pct   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [dmsd_pkg::FS_W-1:0]     rsp_down_level;
   logic [dmsd_pkg::FS_W-1:0]     rsp_up_level;
   logic                          rsp_stale;
   logic                          rsp_moved;
   logic                          csr_psel     = 1'b0;
   logic                          csr_penable  = 1'b0;
   logic                          csr_pwrite   = 1'b0;
   logic [dmsd_pkg::ADDR_W-1:0]   csr_paddr    = '0;
   logic [dmsd_pkg::DATA_W-1:0]   csr_pwdata   = '0;
   logic [dmsd_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   // Percent chance per cycle that the request side holds back or the
   // response side stalls.
   int unsigned send_idle_pct = 8;
   int unsigned rcv_idle_pct  = 88;
   int unsigned mismatch_count = 0;

   // Predicted state of the block and its registers.
   dmsd_pkg::cfg_type                model_cfg;
   logic [dmsd_pkg::FS_W-1:0]        down_tgt, up_tgt, down_lvl, up_lvl;
   logic [dmsd_pkg::SINCE_W-1:0]     since_set;

   // Readings predicted for requests already transferred, oldest first.
   meter_reading_type   pending_readings[$];

   dual_meter_slew_driver_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_down_pct   (req_down_pct),
      .req_up_pct     (req_up_pct),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_down_level (rsp_down_level),
      .rsp_up_level   (rsp_up_level),
      .rsp_stale      (rsp_stale),
      .rsp_moved      (rsp_moved),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #6 clock = ~clock;

   // The response side decides at every falling edge whether to stall.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rcv_idle_pct);
   end

   // Only the first ten mismatches are described; the rest are counted.
   function automatic void note_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s expected %0d actual %0d", $realtime, what, want, got);
      end
   endfunction

   // A percentage saturates at 100 and scales to a DAC code with truncation.
   function automatic logic [dmsd_pkg::FS_W-1:0] pct_to_code(
         input logic [dmsd_pkg::PCT_W-1:0] pct);
      logic [dmsd_pkg::PCT_W-1:0] clamped;
      logic [19:0]                product;
      clamped = (pct > dmsd_pkg::PCT_FULL) ? dmsd_pkg::PCT_FULL : pct;
      product = clamped * model_cfg.full_scale;
      product = product / dmsd_pkg::PCT_FULL;
      // The DAC range clamp can only matter for narrower DAC builds.
      if (product > 20'd4095) begin
         product = 20'd4095;
      end
      return product[dmsd_pkg::FS_W-1:0];
   endfunction

   // One slew step: a hundredth of the distance, raised to min_step in
   // magnitude but never past the target. A min_step of zero lets a step
   // that truncates to zero stay zero.
   function automatic logic [dmsd_pkg::FS_W-1:0] slew_toward(
         input logic [dmsd_pkg::FS_W-1:0] cur,
         input logic [dmsd_pkg::FS_W-1:0] tgt);
      int gap, step, floor_mag;
      gap       = int'(tgt) - int'(cur);
      step      = gap / 100;
      floor_mag = int'(model_cfg.min_step);
      if (gap > 0) begin
         if (step < floor_mag) begin
            step = (gap > floor_mag) ? floor_mag : gap;
         end
      end else if (step > -floor_mag) begin
         step = (gap < -floor_mag) ? -floor_mag : gap;
      end
      return dmsd_pkg::FS_W'(int'(cur) + step);
   endfunction

   // Applies one request to the predicted state and returns the reading the
   // block must report for it.
   function automatic meter_reading_type meter_predict(
         input logic [dmsd_pkg::CMD_W-1:0] cmd,
         input logic [dmsd_pkg::PCT_W-1:0] down_pct,
         input logic [dmsd_pkg::PCT_W-1:0] up_pct);
      meter_reading_type r;
      logic [dmsd_pkg::FS_W-1:0] nd, nu;
      r.moved = 1'b0;
      case (cmd)
         dmsd_pkg::CMD_SET: begin
            down_tgt  = pct_to_code(down_pct);
            up_tgt    = pct_to_code(up_pct);
            since_set = '0;
         end
         dmsd_pkg::CMD_MOVE: begin
            nd = down_lvl;
            nu = up_lvl;
            if (up_lvl != up_tgt) begin
               nu = slew_toward(up_lvl, up_tgt);
            end
            if (down_lvl != down_tgt) begin
               nd = slew_toward(down_lvl, down_tgt);
            end
            r.moved  = (nd != down_lvl) || (nu != up_lvl);
            down_lvl = nd;
            up_lvl   = nu;
         end
         dmsd_pkg::CMD_TICK: begin
            // The millisecond count sticks at its maximum.
            if (since_set != dmsd_pkg::SINCE_MAX) begin
               since_set = since_set + 1'b1;
            end
         end
         default: begin
            // The unused code leaves everything as it is.
         end
      endcase
      r.down_level = down_lvl;
      r.up_level   = up_lvl;
      r.stale      = (since_set > model_cfg.stale_limit_ms);
      return r;
   endfunction

   // Everything is observed at the rising edge: register writes update the
   // predicted configuration, each response transfer is checked against the
   // oldest pending reading, and each request transfer adds a new one. A
   // response can never belong to a request transferred at the same edge.
   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         model_cfg.full_scale     = dmsd_pkg::FULL_SCALE_RST;
         model_cfg.min_step       = dmsd_pkg::MIN_STEP_RST;
         model_cfg.stale_limit_ms = dmsd_pkg::STALE_LIM_RST;
         down_tgt  = '0;
         up_tgt    = '0;
         down_lvl  = '0;
         up_lvl    = '0;
         since_set = '0;
         pending_readings.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (dmsd_pkg::reg_idx_type'(csr_paddr[3:2]))
               dmsd_pkg::REG_FULL_SCALE:
                  model_cfg.full_scale     = csr_pwdata[dmsd_pkg::FS_W-1:0];
               dmsd_pkg::REG_MIN_STEP:
                  model_cfg.min_step       = csr_pwdata[dmsd_pkg::MS_W-1:0];
               dmsd_pkg::REG_STALE_LIM:
                  model_cfg.stale_limit_ms = csr_pwdata[dmsd_pkg::LIM_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               note_mismatch("response with nothing pending, down_level", 0,
                             rsp_down_level);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_down_level !== want.down_level) begin
                  note_mismatch("down_level", want.down_level, rsp_down_level);
               end
               if (rsp_up_level !== want.up_level) begin
                  note_mismatch("up_level", want.up_level, rsp_up_level);
               end
               if (rsp_stale !== want.stale) begin
                  note_mismatch("stale", want.stale, rsp_stale);
               end
               if (rsp_moved !== want.moved) begin
                  note_mismatch("moved", want.moved, rsp_moved);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_readings.push_back(meter_predict(req_cmd, req_down_pct, req_up_pct));
         end
      end
   end

   // Offers one request and returns once it has been transferred. The valid
   // line stays high between back-to-back requests and only drops for a gap.
   task automatic send_request(input logic [dmsd_pkg::CMD_W-1:0] cmd,
                               input logic [dmsd_pkg::PCT_W-1:0] down_pct,
                               input logic [dmsd_pkg::PCT_W-1:0] up_pct);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_down_pct = down_pct;
      req_up_pct   = up_pct;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Holds the request side back until every pending reading has arrived.
   task automatic wait_all_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes a register once the block is idle, then reads it back.
   task automatic csr_write(input dmsd_pkg::reg_idx_type idx,
                            input logic [dmsd_pkg::DATA_W-1:0] value);
      logic [dmsd_pkg::DATA_W-1:0] mask;
      wait_all_results();
      case (idx)
         dmsd_pkg::REG_FULL_SCALE: mask = (1 << dmsd_pkg::FS_W) - 1;
         dmsd_pkg::REG_MIN_STEP:   mask = (1 << dmsd_pkg::MS_W) - 1;
         default:                  mask = (1 << dmsd_pkg::LIM_W) - 1;
      endcase
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (csr_prdata !== (value & mask)) begin
         note_mismatch("register read back", value & mask, csr_prdata);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Random traffic shaped like real use: sets now and then, mostly moves
   // that walk the levels toward their targets, ticks that age the set, and a
   // few unused codes. Most percentages are in range; the rest use all bits.
   task automatic random_burst(input int count);
      int roll;
      logic [dmsd_pkg::CMD_W-1:0] cmd;
      logic [dmsd_pkg::PCT_W-1:0] down_pct, up_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) == 0) begin
            wait_all_results();
         end
         roll = $urandom_range(99);
         if (roll < 15) begin
            cmd = dmsd_pkg::CMD_SET;
         end else if (roll < 70) begin
            cmd = dmsd_pkg::CMD_MOVE;
         end else if (roll < 95) begin
            cmd = dmsd_pkg::CMD_TICK;
         end else begin
            cmd = CMD_UNUSED;
         end
         down_pct = dmsd_pkg::PCT_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                              : $urandom_range(100));
         up_pct   = dmsd_pkg::PCT_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                              : $urandom_range(100));
         send_request(cmd, down_pct, up_pct);
      end
   endtask

   // Set scaling with the reset registers, saturation above 100 percent,
   // slewing in both directions and the unused command code.
   task automatic test_set_and_move();
      send_request(dmsd_pkg::CMD_SET, 8'd100, 8'd50);
      repeat (3) send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd255, 8'd101);
      send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd0, 8'd0);
      repeat (2) send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
      send_request(CMD_UNUSED, 8'd7, 8'd9);
   endtask

   // With no minimum step, small distances truncate to a zero step and the
   // levels stop short of their targets.
   task automatic test_min_step_zero();
      csr_write(dmsd_pkg::REG_MIN_STEP, 32'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd1, 8'd2);
      repeat (3) send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
   endtask

   // A zero limit makes the flag rise on the first tick; a set clears it.
   task automatic test_stale_flag();
      csr_write(dmsd_pkg::REG_STALE_LIM, 32'd0);
      repeat (2) send_request(dmsd_pkg::CMD_TICK, 8'd0, 8'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd30, 8'd60);
      send_request(dmsd_pkg::CMD_TICK, 8'd0, 8'd0);
   endtask

   // Largest and smallest full scale, with the largest minimum step.
   task automatic test_scale_extremes();
      csr_write(dmsd_pkg::REG_FULL_SCALE, 32'd4095);
      csr_write(dmsd_pkg::REG_MIN_STEP, 32'd255);
      send_request(dmsd_pkg::CMD_SET, 8'd100, 8'd255);
      repeat (2) send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
      csr_write(dmsd_pkg::REG_FULL_SCALE, 32'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd100, 8'd100);
      send_request(dmsd_pkg::CMD_MOVE, 8'd0, 8'd0);
   endtask

   // Several register settings, each followed by a run of random traffic,
   // with the idling pattern changing every two settings.
   task automatic test_random_phases();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               rcv_idle_pct  = 88;
               csr_write(dmsd_pkg::REG_FULL_SCALE, 32'd3722);
               csr_write(dmsd_pkg::REG_MIN_STEP, 32'd10);
               csr_write(dmsd_pkg::REG_STALE_LIM, 32'd5);
            end
            1: begin
               csr_write(dmsd_pkg::REG_FULL_SCALE, 32'd4095);
               csr_write(dmsd_pkg::REG_MIN_STEP, 32'd1);
               csr_write(dmsd_pkg::REG_STALE_LIM, 32'd0);
            end
            2: begin
               send_idle_pct = 88;
               rcv_idle_pct  = 8;
               csr_write(dmsd_pkg::REG_FULL_SCALE, $urandom_range(4095));
               csr_write(dmsd_pkg::REG_MIN_STEP, $urandom_range(255, 1));
               csr_write(dmsd_pkg::REG_STALE_LIM, $urandom_range(12));
            end
            3: begin
               csr_write(dmsd_pkg::REG_FULL_SCALE, 32'd0);
               csr_write(dmsd_pkg::REG_MIN_STEP, 32'd255);
               csr_write(dmsd_pkg::REG_STALE_LIM, 32'd65535);
            end
            4: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
               csr_write(dmsd_pkg::REG_FULL_SCALE, $urandom_range(4095));
               csr_write(dmsd_pkg::REG_MIN_STEP, 32'd0);
               csr_write(dmsd_pkg::REG_STALE_LIM, $urandom_range(12));
            end
            default: begin
               csr_write(dmsd_pkg::REG_FULL_SCALE, $urandom_range(4095));
               csr_write(dmsd_pkg::REG_MIN_STEP, $urandom_range(255));
               csr_write(dmsd_pkg::REG_STALE_LIM, $urandom_range(12));
            end
         endcase
         random_burst(175);
      end
   endtask

   // A run of back-to-back ticks carries the millisecond count past a small
   // limit so the flag rises, then a set clears it. Runs without any idling.
   task automatic test_tick_run();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      csr_write(dmsd_pkg::REG_STALE_LIM, 32'd16);
      send_request(dmsd_pkg::CMD_SET, 8'd40, 8'd80);
      repeat (24) send_request(dmsd_pkg::CMD_TICK, 8'd0, 8'd0);
      send_request(dmsd_pkg::CMD_SET, 8'd10, 8'd20);
      send_request(dmsd_pkg::CMD_TICK, 8'd0, 8'd0);
   endtask

   // Main sequence: reset once, the directed tests, the random phases and the
   // tick run, then drain and report.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_set_and_move();
      test_min_step_zero();
      test_stale_flag();
      test_scale_extremes();
      test_random_phases();
      test_tick_run();
      wait_all_results();
      // Keep running a little so that a stray extra response would be caught.
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("dual_meter_slew_driver_unit: match");
      end else begin
         $display("dual_meter_slew_driver_unit: mismatch");
      end
      $finish;
   end

   // A hung handshake ends the run here. The longest correct run stays well
   // below a millisecond of simulated time.
   initial begin
      #20000000;
      $display("dual_meter_slew_driver_unit: mismatch");
      $finish;
   end

endmodule

[dual_meter_slew_driver_unit.f]
design/dmsd_pkg.sv
design/dmsd_div100.sv
design/dmsd_slew.sv
design/dmsd_csr.sv
design/dual_meter_slew_driver_unit.sv
verif/dual_meter_slew_driver_unit_tb.sv
